### rtl/dfd_pkg.sv
// Shared types and constants for the DLE/STX/ETX frame decoder.
// No dependencies; used by dfd_out_reg and dle_frame_decoder.
`default_nettype none

package dfd_pkg;

  // Framing characters
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_DLE = 8'h10;

  // Escaped characters that lose the escape offset
  localparam logic [7:0] ESC_STX_CODE = 8'h42;
  localparam logic [7:0] ESC_ETX_CODE = 8'h43;
  localparam logic [7:0] ESC_CR_CODE  = 8'h4D;
  localparam logic [7:0] ESC_OFFSET   = 8'h40;

  // Field widths fixed by the interface
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned DLEN_W  = 16;
  localparam int unsigned RLEN_W  = 18;
  localparam logic [RLEN_W-1:0] READ_MAX = 18'h3FFFF;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  // One result item
  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] data;
    logic [DLEN_W-1:0] dlen;
    logic [RLEN_W-1:0] rlen;
  } result_t;

  // True for a byte that is legal after DLE
  function automatic logic is_esc_code(input logic [7:0] b);
    return (b == CH_DLE) || (b == ESC_STX_CODE) || (b == ESC_ETX_CODE) ||
           (b == ESC_CR_CODE);
  endfunction

  // Map a legal escaped byte back to its raw value
  function automatic logic [7:0] unescape(input logic [7:0] b);
    return (b == CH_DLE) ? CH_DLE : (b - ESC_OFFSET);
  endfunction

endpackage

`default_nettype wire

### rtl/dfd_out_reg.sv
// One-entry result register for the frame decoder's output channel.
// Depends on dfd_pkg for the result_t record.
`default_nettype none

module dfd_out_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire logic            load_has_res,
  input  wire dfd_pkg::result_t load_res,
  output logic                 slot_free,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output dfd_pkg::result_t     out_res
);

  logic             valid_r;
  dfd_pkg::result_t res_r;

  // Free when empty or when the held result leaves this cycle
  assign slot_free = !valid_r || out_ready;

  // Control: load a new result, or drop the taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= load_has_res;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload: capture only on a new result
  always_ff @(posedge clk) begin
    if (load && load_has_res) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

  // A held result stays put until it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(res_r))
    else $error("held result changed before it was taken");

  // Loading is only allowed into a free slot
  assert property (@(posedge clk) disable iff (!rst_n)
    load |-> slot_free)
    else $error("result loaded into an occupied slot");

  // Taken result with no new load empties the slot
  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_ready && !load |=> !valid_r)
    else $error("taken result was not dropped");

endmodule

`default_nettype wire

### rtl/dle_frame_decoder.sv
// DLE/STX/ETX byte unstuffing decoder, one encoded byte per request; uses dfd_pkg, dfd_out_reg.
// Output: each result is registered and appears on out_* in the cycle after its byte is accepted.
// Throughput: one byte per cycle; in_ready is low only while a result waits
//   in the output register and out_ready is low.
// Reset (rst_n low, synchronous): phase idle, counts zero, limit 16'hFFFF,
//   output register empty.
`default_nettype none

module dle_frame_decoder #(
  parameter int unsigned LEN_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_encoded_byte,
  input  wire logic        in_buffer_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_data_byte,
  output logic [15:0]      out_decoded_len,
  output logic [17:0]      out_read_len
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FRAME = 2'd1,
    PH_ESC   = 2'd2
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [LEN_WIDTH-1:0]        dcnt_r, dcnt_nxt;
  logic [LEN_WIDTH-1:0]        max_len_r;
  logic [dfd_pkg::RLEN_W-1:0]  rcnt_r, rcnt_nxt, rcnt_inc;
  logic                        accept;
  logic                        has_res;
  logic                        open_nxt;
  logic                        have_data;
  logic [7:0]                  data;
  dfd_pkg::result_t            res;
  dfd_pkg::result_t            out_res;

  assign accept   = in_valid && in_ready;
  assign rcnt_inc = (rcnt_r == dfd_pkg::READ_MAX) ? rcnt_r
                                                  : rcnt_r + dfd_pkg::RLEN_W'(1);

  // Decode one byte: next phase, counts and the result it causes
  always_comb begin
    phase_nxt = phase_r;
    dcnt_nxt  = dcnt_r;
    rcnt_nxt  = rcnt_r;
    has_res   = 1'b0;
    open_nxt  = 1'b0;
    have_data = 1'b0;
    data      = '0;
    res       = '{kind: dfd_pkg::KIND_FAIL, data: '0, dlen: '0, rlen: '0};

    unique case (phase_r)
      PH_IDLE: begin
        if (in_encoded_byte != dfd_pkg::CH_STX) begin
          has_res = 1'b1;
        end else begin
          phase_nxt = PH_FRAME;
          dcnt_nxt  = '0;
          rcnt_nxt  = dfd_pkg::RLEN_W'(1);
          open_nxt  = 1'b1;
        end
      end
      PH_FRAME: begin
        if (in_encoded_byte == dfd_pkg::CH_ETX) begin
          has_res   = 1'b1;
          res.kind  = dfd_pkg::KIND_DONE;
          res.dlen  = dfd_pkg::DLEN_W'(dcnt_r);
          res.rlen  = rcnt_inc;
          phase_nxt = PH_IDLE;
          dcnt_nxt  = '0;
          rcnt_nxt  = '0;
        end else if (dcnt_r >= max_len_r || in_encoded_byte == dfd_pkg::CH_STX) begin
          has_res   = 1'b1;
          phase_nxt = PH_IDLE;
          dcnt_nxt  = '0;
          rcnt_nxt  = '0;
        end else begin
          rcnt_nxt = rcnt_inc;
          open_nxt = 1'b1;
          if (in_encoded_byte == dfd_pkg::CH_DLE) begin
            phase_nxt = PH_ESC;
          end else begin
            have_data = 1'b1;
            data      = in_encoded_byte;
          end
        end
      end
      PH_ESC: begin
        if (dfd_pkg::is_esc_code(in_encoded_byte)) begin
          have_data = 1'b1;
          data      = dfd_pkg::unescape(in_encoded_byte);
          rcnt_nxt  = rcnt_inc;
          phase_nxt = PH_FRAME;
          open_nxt  = 1'b1;
        end else begin
          has_res   = 1'b1;
          phase_nxt = PH_IDLE;
          dcnt_nxt  = '0;
          rcnt_nxt  = '0;
        end
      end
      default: begin
        has_res   = 1'b1;
        phase_nxt = PH_IDLE;
        dcnt_nxt  = '0;
        rcnt_nxt  = '0;
      end
    endcase

    // Count decoded bytes
    if (have_data) begin
      dcnt_nxt = dcnt_r + LEN_WIDTH'(1);
    end

    // Buffer ended with the frame still open: fail instead of data
    if (open_nxt) begin
      if (in_buffer_end) begin
        has_res   = 1'b1;
        phase_nxt = PH_IDLE;
        dcnt_nxt  = '0;
        rcnt_nxt  = '0;
      end else if (have_data) begin
        has_res   = 1'b1;
        res.kind  = dfd_pkg::KIND_DATA;
        res.data  = data;
      end
    end
  end

  // Phase and counters advance on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      dcnt_r  <= '0;
      rcnt_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      dcnt_r  <= dcnt_nxt;
      rcnt_r  <= rcnt_nxt;
    end
  end

  // Length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= LEN_WIDTH'(16'hFFFF);
    end else if (cfg_wr_en) begin
      max_len_r <= LEN_WIDTH'(cfg_wr_data);
    end
  end

  dfd_out_reg u_out_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (accept),
    .load_has_res (has_res),
    .load_res     (res),
    .slot_free    (in_ready),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_res      (out_res)
  );

  assign out_result_kind = out_res.kind;
  assign out_data_byte   = out_res.data;
  assign out_decoded_len = out_res.dlen;
  assign out_read_len    = out_res.rlen;

  // Idle means no frame is counted
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> dcnt_r == '0 && rcnt_r == '0)
    else $error("counts not cleared while idle");

  // An open frame has read at least its STX
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> rcnt_r != '0)
    else $error("open frame with zero read count");

  // Only a completed frame carries lengths
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != dfd_pkg::KIND_DONE |->
      out_decoded_len == '0 && out_read_len == '0)
    else $error("lengths on a non-complete result");

  // STX right after DLE fails the frame
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_ESC && in_encoded_byte == dfd_pkg::CH_STX |=>
      out_valid && out_result_kind == dfd_pkg::KIND_FAIL && phase_r == PH_IDLE)
    else $error("escaped STX did not fail the frame");

endmodule

`default_nettype wire
